// ===== rtl/core/uite_pkg.sv =====
// Package for the interrupt-driven UART transfer engine.
// Holds the item types, action and register codes, masks and enable bit positions.
// Used by the channel interfaces and the top level.
package uite_pkg;

	localparam int unsigned MAX_TRANSFER_BYTES = 65535;

	typedef enum logic [1:0] {
		ACT_TX_START = 2'd0,
		ACT_RX_START = 2'd1,
		ACT_SERVICE  = 2'd2,
		ACT_NONE     = 2'd3
	} action_t;

	localparam logic [2:0] CFG_NINE_BIT_WORDS    = 3'd0;
	localparam logic [2:0] CFG_PARITY_ENABLED    = 3'd1;
	localparam logic [2:0] CFG_CTS_IRQ_ENABLED   = 3'd2;
	localparam logic [2:0] CFG_IDLE_IRQ_ENABLED  = 3'd3;
	localparam logic [2:0] CFG_ERROR_IRQ_ENABLED = 3'd4;

	localparam int unsigned EN_TXE  = 0;
	localparam int unsigned EN_TC   = 1;
	localparam int unsigned EN_RXNE = 2;

	localparam int unsigned SF_TC      = 0;
	localparam int unsigned SF_TXE     = 1;
	localparam int unsigned SF_RXNE    = 2;
	localparam int unsigned SF_CTS     = 3;
	localparam int unsigned SF_IDLE    = 4;
	localparam int unsigned SF_OVERRUN = 5;
	localparam int unsigned SF_NOISE   = 6;
	localparam int unsigned SF_FRAMING = 7;

	localparam int unsigned EV_TX_DONE = 0;
	localparam int unsigned EV_RX_DONE = 1;
	localparam int unsigned EV_CTS     = 2;
	localparam int unsigned EV_IDLE    = 3;
	localparam int unsigned EV_OVERRUN = 4;
	localparam int unsigned EV_NOISE   = 5;
	localparam int unsigned EV_FRAMING = 6;

	localparam int unsigned CLR_TC   = 0;
	localparam int unsigned CLR_CTS  = 1;
	localparam int unsigned CLR_READ = 2;

	localparam logic [8:0] MASK_NINE  = 9'h1ff;
	localparam logic [8:0] MASK_EIGHT = 9'h0ff;
	localparam logic [8:0] MASK_SEVEN = 9'h07f;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] transfer_length;
		logic [7:0]  status_flags;
		logic [8:0]  rx_data;
		logic [15:0] tx_source_data;
	} event_t;

	typedef struct packed {
		logic        prior_busy;
		logic        tx_write_valid;
		logic [8:0]  tx_write_data;
		logic [15:0] tx_read_offset;
		logic        rx_write_valid;
		logic [8:0]  rx_write_data;
		logic [15:0] rx_write_offset;
		logic        rx_write_two_bytes;
		logic [6:0]  event_bits;
		logic [2:0]  clear_requests;
		logic [2:0]  irq_enables;
	} result_t;

	typedef struct packed {
		logic nine_bit_words;
		logic parity_enabled;
		logic cts_irq_enabled;
		logic idle_irq_enabled;
		logic error_irq_enabled;
	} config_t;

endpackage

// ===== rtl/core/uite_if.sv =====
// Valid/ready channel interfaces for the UART transfer engine.
// One carries event items in, the other carries result items out; types from uite_pkg.
interface uite_evt_if import uite_pkg::*; ();
	logic   valid;
	logic   ready;
	event_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface uite_res_if import uite_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/uart_irq_transfer_engine_unit.sv =====
// Top level of the interrupt-driven UART transfer engine.
// Depends on uite_pkg and the channel interfaces in uite_if.sv.
//
// Channel   Direction  Payload
// evt       in         action, transfer_length, status_flags, rx_data, tx_source_data
// res       out        one result item per event item
// cfg       in         write enable, 3-bit register index, 1-bit data
//
// An event item is taken into the input register, evaluated combinationally against
// the transfer state and written to the result register.
// One item is accepted every cycle while results are being taken.
// A stalled result holds; the input register still takes one further item.
// Reset clears the transfer state, the interrupt enables and all registers.
module uart_irq_transfer_engine_unit import uite_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic          cfg_wdata,
	uite_evt_if.sink      evt,
	uite_res_if.source    res
);

	config_t     cfg_q;
	logic        tx_busy_q, rx_busy_q;
	logic [15:0] tx_rem_q, tx_off_q, rx_rem_q, rx_off_q;
	logic [2:0]  irq_en_q;

	event_t      evt_s1;
	logic        valid_s1;
	result_t     res_q;
	logic        res_valid_q;
	logic        advance;

	logic        tx_busy_d, rx_busy_d;
	logic [15:0] tx_rem_d, tx_off_d, rx_rem_d, rx_off_d;
	logic [2:0]  irq_en_d;
	result_t     res_d;

	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign evt.ready = !valid_s1 || advance;
	assign res.valid = res_valid_q;
	assign res.data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NINE_BIT_WORDS:    cfg_q.nine_bit_words    <= cfg_wdata;
				CFG_PARITY_ENABLED:    cfg_q.parity_enabled    <= cfg_wdata;
				CFG_CTS_IRQ_ENABLED:   cfg_q.cts_irq_enabled   <= cfg_wdata;
				CFG_IDLE_IRQ_ENABLED:  cfg_q.idle_irq_enabled  <= cfg_wdata;
				CFG_ERROR_IRQ_ENABLED: cfg_q.error_irq_enabled <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		logic        wide;
		logic [8:0]  mask;
		logic [15:0] step;
		logic [15:0] len;
		logic [7:0]  sf;

		wide = cfg_q.nine_bit_words && !cfg_q.parity_enabled;
		if (wide) begin
			mask = MASK_NINE;
		end else if (!cfg_q.nine_bit_words && cfg_q.parity_enabled) begin
			mask = MASK_SEVEN;
		end else begin
			mask = MASK_EIGHT;
		end
		step = wide ? 16'd2 : 16'd1;
		len  = ({8'd0, evt_s1.transfer_length} > 24'(MAX_TRANSFER_BYTES)) ?
			16'(MAX_TRANSFER_BYTES) : evt_s1.transfer_length;
		sf   = evt_s1.status_flags;

		tx_busy_d = tx_busy_q;
		rx_busy_d = rx_busy_q;
		tx_rem_d  = tx_rem_q;
		tx_off_d  = tx_off_q;
		rx_rem_d  = rx_rem_q;
		rx_off_d  = rx_off_q;
		irq_en_d  = irq_en_q;
		res_d     = '0;

		unique case (action_t'(evt_s1.action))
			ACT_TX_START: begin
				res_d.prior_busy = tx_busy_q;
				if (!tx_busy_q) begin
					tx_rem_d = len;
					tx_off_d = '0;
					tx_busy_d = 1'b1;
					irq_en_d[EN_TXE] = 1'b1;
					irq_en_d[EN_TC] = 1'b1;
				end
			end
			ACT_RX_START: begin
				res_d.prior_busy = rx_busy_q;
				if (!rx_busy_q) begin
					rx_rem_d = len;
					rx_off_d = '0;
					rx_busy_d = 1'b1;
					irq_en_d[EN_RXNE] = 1'b1;
				end
			end
			ACT_SERVICE: begin
				if (sf[SF_TC] && irq_en_d[EN_TC] && tx_busy_d && tx_rem_d == '0) begin
					res_d.clear_requests[CLR_TC] = 1'b1;
					irq_en_d[EN_TC] = 1'b0;
					tx_busy_d = 1'b0;
					res_d.event_bits[EV_TX_DONE] = 1'b1;
				end
				if (sf[SF_TXE] && irq_en_d[EN_TXE] && tx_busy_d) begin
					if (tx_rem_d != '0) begin
						res_d.tx_write_valid = 1'b1;
						res_d.tx_write_data  = evt_s1.tx_source_data[8:0] & mask;
						res_d.tx_read_offset = tx_off_q;
						tx_off_d = tx_off_q + step;
						tx_rem_d = (tx_rem_q > step) ? tx_rem_q - step : '0;
					end
					if (tx_rem_d == '0) begin
						irq_en_d[EN_TXE] = 1'b0;
					end
				end
				if (sf[SF_RXNE] && irq_en_d[EN_RXNE] && rx_busy_q && rx_rem_q != '0) begin
					res_d.rx_write_valid     = 1'b1;
					res_d.rx_write_data      = evt_s1.rx_data & mask;
					res_d.rx_write_offset    = rx_off_q;
					res_d.rx_write_two_bytes = wide;
					rx_off_d = rx_off_q + step;
					rx_rem_d = (rx_rem_q > step) ? rx_rem_q - step : '0;
					if (rx_rem_d == '0) begin
						irq_en_d[EN_RXNE] = 1'b0;
						rx_busy_d = 1'b0;
						res_d.event_bits[EV_RX_DONE] = 1'b1;
					end
				end
				if (sf[SF_CTS] && cfg_q.cts_irq_enabled) begin
					res_d.clear_requests[CLR_CTS] = 1'b1;
					res_d.event_bits[EV_CTS] = 1'b1;
				end
				if (sf[SF_IDLE] && cfg_q.idle_irq_enabled) begin
					res_d.clear_requests[CLR_READ] = 1'b1;
					res_d.event_bits[EV_IDLE] = 1'b1;
				end
				if (sf[SF_OVERRUN] && irq_en_d[EN_RXNE]) begin
					res_d.clear_requests[CLR_READ] = 1'b1;
					res_d.event_bits[EV_OVERRUN] = 1'b1;
				end
				if (cfg_q.error_irq_enabled) begin
					if (sf[SF_NOISE]) begin
						res_d.clear_requests[CLR_READ] = 1'b1;
						res_d.event_bits[EV_NOISE] = 1'b1;
					end else if (sf[SF_FRAMING]) begin
						res_d.clear_requests[CLR_READ] = 1'b1;
						res_d.event_bits[EV_FRAMING] = 1'b1;
					end
				end
			end
			default: ;
		endcase

		res_d.irq_enables = irq_en_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			evt_s1      <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
			tx_busy_q   <= 1'b0;
			rx_busy_q   <= 1'b0;
			tx_rem_q    <= '0;
			tx_off_q    <= '0;
			rx_rem_q    <= '0;
			rx_off_q    <= '0;
			irq_en_q    <= '0;
		end else begin
			if (evt.valid && evt.ready) begin
				evt_s1 <= evt.data;
			end
			if (evt.ready) begin
				valid_s1 <= evt.valid;
			end
			if (advance) begin
				res_q     <= res_d;
				tx_busy_q <= tx_busy_d;
				rx_busy_q <= rx_busy_d;
				tx_rem_q  <= tx_rem_d;
				tx_off_q  <= tx_off_d;
				rx_rem_q  <= rx_rem_d;
				rx_off_q  <= rx_off_d;
				irq_en_q  <= irq_en_d;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	a_tx_done_idles: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res_d.event_bits[EV_TX_DONE] |=> !tx_busy_q)
		else $error("Transmit stayed busy after its done event.");

	a_rx_idle_no_rxne: assert property (@(posedge clk) disable iff (!arst_n)
		!rx_busy_q |-> !irq_en_q[EN_RXNE])
		else $error("Receive interrupt enabled while receive is idle.");

	a_tx_idle_no_tc: assert property (@(posedge clk) disable iff (!arst_n)
		!tx_busy_q |-> !irq_en_q[EN_TC])
		else $error("Transmit-complete enable set while transmit is idle.");

	a_tx_word_masked: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.tx_write_valid && !cfg_q.nine_bit_words
		|-> !res_q.tx_write_data[8])
		else $error("Eight-bit transmit word carries a ninth bit.");

	a_result_enables: assert property (@(posedge clk) disable iff (!arst_n)
		$past(advance) |-> res_q.irq_enables == irq_en_q)
		else $error("Reported interrupt enables differ from the state.");

endmodule

// ===== tb/tb_uart_irq_transfer_engine_unit.sv =====
// Self-checking testbench for uart_irq_transfer_engine_unit: a queue-fed driver, a monitor
// that predicts each result item from its own copy of the transfer state, and a watchdog.
// Depends on uite_pkg, the channel interfaces in uite_if.sv and the top level of the block.
module tb_uart_irq_transfer_engine_unit;
	import uite_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned SETTLE_CYCLES  = 6;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [2:0] cfg_index;
	logic       cfg_wdata;

	uite_evt_if evt ();
	uite_res_if res ();

	uart_irq_transfer_engine_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.evt       (evt),
		.res       (res)
	);

	config_t     cur_cfg = '0;
	logic        tx_busy_q = 1'b0;
	logic        rx_busy_q = 1'b0;
	logic [15:0] tx_left = '0;
	logic [15:0] tx_pos = '0;
	logic [15:0] rx_left = '0;
	logic [15:0] rx_pos = '0;
	logic [2:0]  enables_q = '0;

	event_t      pending_events[$];
	result_t     awaited_results[$];
	int unsigned n_queued = 0;
	int unsigned n_taken = 0;
	int unsigned quiet_cycles = 0;
	int unsigned mismatches = 0;
	logic        gaps_on = 1'b1;
	logic        evt_fired = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [15:0] clamp_length(logic [15:0] len);
		return (32'(len) > MAX_TRANSFER_BYTES) ? 16'(MAX_TRANSFER_BYTES) : len;
	endfunction

	function automatic result_t engine_step(event_t ev);
		result_t     r;
		logic        wide;
		logic [8:0]  mask;
		logic [15:0] stride;
		logic [6:0]  ev_bits;
		logic [2:0]  clr;
		logic [7:0]  sf;
		r = '0;
		ev_bits = '0;
		clr = '0;
		sf = ev.status_flags;
		wide = cur_cfg.nine_bit_words && !cur_cfg.parity_enabled;
		if (wide)
			mask = MASK_NINE;
		else if (!cur_cfg.nine_bit_words && cur_cfg.parity_enabled)
			mask = MASK_SEVEN;
		else
			mask = MASK_EIGHT;
		stride = wide ? 16'd2 : 16'd1;
		case (action_t'(ev.action))
		ACT_TX_START: begin
			r.prior_busy = tx_busy_q;
			if (!tx_busy_q) begin
				tx_left = clamp_length(ev.transfer_length);
				tx_pos = '0;
				tx_busy_q = 1'b1;
				enables_q[EN_TXE] = 1'b1;
				enables_q[EN_TC] = 1'b1;
			end
		end
		ACT_RX_START: begin
			r.prior_busy = rx_busy_q;
			if (!rx_busy_q) begin
				rx_left = clamp_length(ev.transfer_length);
				rx_pos = '0;
				rx_busy_q = 1'b1;
				enables_q[EN_RXNE] = 1'b1;
			end
		end
		ACT_SERVICE: begin
			if (sf[SF_TC] && enables_q[EN_TC] && tx_busy_q && tx_left == 0) begin
				clr[CLR_TC] = 1'b1;
				enables_q[EN_TC] = 1'b0;
				tx_busy_q = 1'b0;
				ev_bits[EV_TX_DONE] = 1'b1;
			end
			if (sf[SF_TXE] && enables_q[EN_TXE] && tx_busy_q) begin
				if (tx_left != 0) begin
					r.tx_write_valid = 1'b1;
					r.tx_write_data = ev.tx_source_data[8:0] & mask;
					r.tx_read_offset = tx_pos;
					tx_pos = tx_pos + stride;
					tx_left = (tx_left > stride) ? tx_left - stride : 16'd0;
				end
				if (tx_left == 0)
					enables_q[EN_TXE] = 1'b0;
			end
			if (sf[SF_RXNE] && enables_q[EN_RXNE] && rx_busy_q && rx_left != 0) begin
				r.rx_write_valid = 1'b1;
				r.rx_write_data = ev.rx_data & mask;
				r.rx_write_offset = rx_pos;
				r.rx_write_two_bytes = wide;
				rx_pos = rx_pos + stride;
				rx_left = (rx_left > stride) ? rx_left - stride : 16'd0;
				if (rx_left == 0) begin
					enables_q[EN_RXNE] = 1'b0;
					rx_busy_q = 1'b0;
					ev_bits[EV_RX_DONE] = 1'b1;
				end
			end
			if (sf[SF_CTS] && cur_cfg.cts_irq_enabled) begin
				clr[CLR_CTS] = 1'b1;
				ev_bits[EV_CTS] = 1'b1;
			end
			if (sf[SF_IDLE] && cur_cfg.idle_irq_enabled) begin
				clr[CLR_READ] = 1'b1;
				ev_bits[EV_IDLE] = 1'b1;
			end
			if (sf[SF_OVERRUN] && enables_q[EN_RXNE]) begin
				clr[CLR_READ] = 1'b1;
				ev_bits[EV_OVERRUN] = 1'b1;
			end
			if (cur_cfg.error_irq_enabled) begin
				if (sf[SF_NOISE]) begin
					clr[CLR_READ] = 1'b1;
					ev_bits[EV_NOISE] = 1'b1;
				end else if (sf[SF_FRAMING]) begin
					clr[CLR_READ] = 1'b1;
					ev_bits[EV_FRAMING] = 1'b1;
				end
			end
			r.event_bits = ev_bits;
			r.clear_requests = clr;
		end
		default: begin
		end
		endcase
		r.irq_enables = enables_q;
		return r;
	endfunction

	task automatic note_mismatch(string what);
		mismatches++;
		$display("tb: mismatch: %s", what);
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			note_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	always @(posedge clk) begin : monitor
		result_t got;
		result_t want;
		got = res.data;
		if (res.valid && res.ready) begin
			if (awaited_results.size() == 0) begin
				note_mismatch("result item with no item awaited");
			end else begin
				want = awaited_results.pop_front();
				check_field("prior_busy", 32'(got.prior_busy), 32'(want.prior_busy));
				check_field("tx_write_valid", 32'(got.tx_write_valid),
					32'(want.tx_write_valid));
				check_field("tx_write_data", 32'(got.tx_write_data),
					32'(want.tx_write_data));
				check_field("tx_read_offset", 32'(got.tx_read_offset),
					32'(want.tx_read_offset));
				check_field("rx_write_valid", 32'(got.rx_write_valid),
					32'(want.rx_write_valid));
				check_field("rx_write_data", 32'(got.rx_write_data),
					32'(want.rx_write_data));
				check_field("rx_write_offset", 32'(got.rx_write_offset),
					32'(want.rx_write_offset));
				check_field("rx_write_two_bytes", 32'(got.rx_write_two_bytes),
					32'(want.rx_write_two_bytes));
				check_field("event_bits", 32'(got.event_bits), 32'(want.event_bits));
				check_field("clear_requests", 32'(got.clear_requests),
					32'(want.clear_requests));
				check_field("irq_enables", 32'(got.irq_enables), 32'(want.irq_enables));
			end
		end
		if (evt.valid && evt.ready) begin
			awaited_results.push_back(engine_step(evt.data));
			n_taken++;
		end
		if ((evt.valid && evt.ready) || (res.valid && res.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		evt_fired <= evt.valid && evt.ready;
	end

	always @(negedge clk) begin : driver
		if (!arst_n) begin
			evt.valid <= 1'b0;
		end else if (!evt.valid || evt_fired) begin
			if (pending_events.size() != 0 && !(gaps_on && $urandom_range(99) < 26)) begin
				evt.data <= pending_events.pop_front();
				evt.valid <= 1'b1;
			end else begin
				evt.valid <= 1'b0;
			end
		end
		res.ready <= gaps_on ? ($urandom_range(99) >= 26) : 1'b1;
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("tb: failure");
		$finish;
	end

	function automatic logic [7:0] sf_bit(int unsigned pos);
		return 8'(1) << pos;
	endfunction

	task automatic queue_event(action_t act, logic [15:0] len, logic [7:0] sf,
		logic [8:0] rxd, logic [15:0] txs);
		event_t e;
		e.action = act;
		e.transfer_length = len;
		e.status_flags = sf;
		e.rx_data = rxd;
		e.tx_source_data = txs;
		pending_events.push_back(e);
		n_queued++;
	endtask

	function automatic logic [15:0] short_length(logic zero_allowed);
		int unsigned p;
		p = $urandom_range(99);
		if (zero_allowed && p < 8)
			return 16'd0;
		if (p < 90)
			return 16'($urandom_range(6, 1));
		return 16'($urandom_range(40, 7));
	endfunction

	task automatic queue_random_event();
		int unsigned pick;
		action_t     act;
		logic [15:0] len;
		logic [7:0]  sf;
		pick = $urandom_range(99);
		len = 16'($urandom);
		sf = 8'($urandom);
		if (pick < 14) begin
			act = ACT_TX_START;
			len = short_length(1'b1);
		end else if (pick < 28) begin
			act = ACT_RX_START;
			len = short_length(1'b0);
		end else if (pick < 92) begin
			act = ACT_SERVICE;
			sf = '0;
			sf[SF_TC] = ($urandom_range(99) < 40);
			sf[SF_TXE] = ($urandom_range(99) < 65);
			sf[SF_RXNE] = ($urandom_range(99) < 65);
			for (int unsigned b = SF_CTS; b <= SF_FRAMING; b++)
				sf[b] = ($urandom_range(99) < 20);
		end else if (pick < 96) begin
			act = ACT_NONE;
		end else begin
			act = action_t'(2'($urandom_range(3, 0)));
			if (act == ACT_TX_START || act == ACT_RX_START)
				len = short_length(act == ACT_TX_START);
		end
		queue_event(act, len, sf, 9'($urandom), 16'($urandom));
	endtask

	task automatic apply_settings(config_t c);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_NINE_BIT_WORDS;
		cfg_wdata <= c.nine_bit_words;
		@(negedge clk);
		cfg_index <= CFG_PARITY_ENABLED;
		cfg_wdata <= c.parity_enabled;
		@(negedge clk);
		cfg_index <= CFG_CTS_IRQ_ENABLED;
		cfg_wdata <= c.cts_irq_enabled;
		@(negedge clk);
		cfg_index <= CFG_IDLE_IRQ_ENABLED;
		cfg_wdata <= c.idle_irq_enabled;
		@(negedge clk);
		cfg_index <= CFG_ERROR_IRQ_ENABLED;
		cfg_wdata <= c.error_irq_enabled;
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_cfg = c;
	endtask

	task automatic wait_drained();
		while (n_taken != n_queued || awaited_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin : stimulus
		config_t c;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = 1'b0;
		evt.valid = 1'b0;
		evt.data = '0;
		res.ready = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		apply_settings(config_t'(5'b00000));
		queue_event(ACT_SERVICE, 16'hffff, 8'hff, 9'h1ff, 16'hffff);
		queue_event(ACT_NONE, 16'hffff, 8'hff, 9'h1ff, 16'hffff);
		queue_event(ACT_TX_START, 16'd0, 8'h00, 9'h000, 16'h0000);
		queue_event(ACT_TX_START, 16'd5, 8'h00, 9'h000, 16'h0000);
		queue_event(ACT_SERVICE, 16'd0, sf_bit(SF_TXE), 9'h000, 16'hffff);
		queue_event(ACT_SERVICE, 16'd0, sf_bit(SF_TC), 9'h000, 16'h0000);
		queue_event(ACT_TX_START, 16'd3, 8'h00, 9'h000, 16'h0000);
		queue_event(ACT_SERVICE, 16'd0, sf_bit(SF_TXE), 9'h000, 16'hffff);
		queue_event(ACT_SERVICE, 16'd0, sf_bit(SF_TXE) | sf_bit(SF_TC), 9'h000, 16'h1234);
		queue_event(ACT_SERVICE, 16'd0, sf_bit(SF_TXE), 9'h000, 16'h00aa);
		queue_event(ACT_SERVICE, 16'd0, sf_bit(SF_TC) | sf_bit(SF_CTS) | sf_bit(SF_IDLE)
			| sf_bit(SF_NOISE) | sf_bit(SF_FRAMING), 9'h000, 16'h0000);
		queue_event(ACT_RX_START, 16'd2, 8'h00, 9'h000, 16'h0000);
		queue_event(ACT_RX_START, 16'd7, 8'h00, 9'h000, 16'h0000);
		queue_event(ACT_SERVICE, 16'd0, sf_bit(SF_RXNE) | sf_bit(SF_OVERRUN), 9'h1ff, 16'h0);
		queue_event(ACT_SERVICE, 16'd0, sf_bit(SF_RXNE) | sf_bit(SF_OVERRUN), 9'h155, 16'h0);
		wait_drained();

		apply_settings(config_t'(5'b10111));
		queue_event(ACT_RX_START, 16'd3, 8'h00, 9'h000, 16'h0000);
		queue_event(ACT_SERVICE, 16'd0, sf_bit(SF_RXNE), 9'h1ff, 16'h0000);
		queue_event(ACT_SERVICE, 16'd0, sf_bit(SF_RXNE) | sf_bit(SF_NOISE)
			| sf_bit(SF_FRAMING), 9'h0ab, 16'h0000);
		queue_event(ACT_SERVICE, 16'd0, sf_bit(SF_FRAMING) | sf_bit(SF_CTS)
			| sf_bit(SF_IDLE) | sf_bit(SF_OVERRUN), 9'h000, 16'h0000);
		queue_event(ACT_TX_START, 16'd1, 8'h00, 9'h000, 16'h0000);
		queue_event(ACT_SERVICE, 16'd0, sf_bit(SF_TXE), 9'h000, 16'hffff);
		queue_event(ACT_SERVICE, 16'd0, sf_bit(SF_TC), 9'h000, 16'h0000);
		wait_drained();

		for (int phase = 0; phase < 8; phase++) begin
			c = config_t'(5'($urandom));
			case (phase)
			0: c = config_t'(5'b11111);
			1: c = config_t'(5'b00000);
			2: begin
				c.nine_bit_words = 1'b1;
				c.parity_enabled = 1'b0;
			end
			3: begin
				c.nine_bit_words = 1'b0;
				c.parity_enabled = 1'b1;
			end
			4: begin
				c.nine_bit_words = 1'b1;
				c.parity_enabled = 1'b1;
			end
			default: begin
			end
			endcase
			gaps_on = (phase != 3);
			apply_settings(c);
			repeat (62) queue_random_event();
			wait_drained();
		end

		// A zero-length receive and a maximum-length transmit never finish, so they come last.
		gaps_on = 1'b1;
		queue_event(ACT_RX_START, 16'd0, 8'h00, 9'h000, 16'h0000);
		queue_event(ACT_SERVICE, 16'd0, sf_bit(SF_RXNE) | sf_bit(SF_OVERRUN), 9'h1ff, 16'h0);
		queue_event(ACT_RX_START, 16'd4, 8'h00, 9'h000, 16'h0000);
		queue_event(ACT_TX_START, 16'hffff, 8'h00, 9'h000, 16'h0000);
		queue_event(ACT_SERVICE, 16'd0, sf_bit(SF_TXE), 9'h000, 16'hbeef);
		queue_event(ACT_SERVICE, 16'hffff, 8'hff, 9'h1ff, 16'hffff);
		wait_drained();

		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
